// File: sv/dti_pkg.sv
`default_nettype none

package dti_pkg;

   // Item kinds carried on req_tuser
   localparam logic [1:0] ACT_WRITE_NODE    = 2'd0;
   localparam logic [1:0] ACT_WRITE_FEATURE = 2'd1;
   localparam logic [1:0] ACT_CLASSIFY      = 2'd2;

   // Result status carried on rsp_tuser
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BAD_FEATURE = 2'd1;
   localparam logic [1:0] ST_DEPTH       = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_NODE_COUNT    = 2'd0;
   localparam logic [1:0] CSR_VISIT_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_FEATURE_COUNT = 2'd2;

   localparam int REQ_TDATA_W = 160;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_DATA_W  = 9;

   localparam logic [7:0] VISIT_LIMIT_RESET   = 8'd5;
   localparam logic [3:0] FEATURE_COUNT_RESET = 4'd5;

   // Request payload, last field (node_index) in the lowest bits
   typedef struct packed {
      logic [4:0]         pad;
      logic signed [31:0] feature_value;
      logic [2:0]         feature_slot;
      logic signed [31:0] leaf_class;
      logic signed [31:0] split_level;
      logic signed [15:0] right_index;
      logic signed [15:0] left_index;
      logic signed [15:0] split_feature;
      logic [7:0]         node_index;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] split_feature;
      logic signed [15:0] left_index;
      logic signed [15:0] right_index;
      logic signed [31:0] split_level;
      logic signed [31:0] leaf_class;
   } node_entry_type;

endpackage

`default_nettype wire

// File: sv/decision_tree_inference.sv
// Decision tree classifier with a loadable node table and feature vector.
// req channel: one item per transfer, req_tuser selects the kind (write node,
// write feature, classify); req_tdata carries the node and feature fields.
// Write items are stored at the transfer edge and give no result. A classify
// item walks the tree from node 0 and gives one result on the rsp channel:
// rsp_tuser holds the status, rsp_tdata the leaf value (zero unless ok).
// csr channel: write node_count, the visit limit and feature_count while
// idle; csr_ready is always high.
// A classify passes a start state, then visits nodes, and ends in a result
// state that loads the output register; the walk ends at a leaf, at a bad
// feature, or on running out of visits or range (even before any node).
// Each visit reads the node memory and then, unless the node is a leaf or
// has a bad feature, the feature memory. Items are taken one at a time; a
// classify holds further items until its result is in the output register.
// Reset returns the control and the registers (node_count 0, visit limit 5,
// feature_count 5); the memories keep their contents and hold nothing
// meaningful until written. If the receiver stalls, a finished result waits
// in the output register, a further item may still be taken, and its walk
// holds at the end until the output register is free.
`default_nettype none

module decision_tree_inference #(
   parameter int NODE_ENTRIES  = 256,
   parameter int FEATURE_SLOTS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // node_index, split_feature, left_index, right_index, split_level,
   // leaf_class, feature_slot, feature_value, zero fill
   input  wire logic [dti_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // class_value
   output logic [dti_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // status
   output logic [1:0]                             rsp_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [dti_pkg::CSR_DATA_W-1:0]    csr_data
);
   import dti_pkg::*;

   localparam int NODE_AW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
   localparam int FS_AW   = (FEATURE_SLOTS > 1) ? $clog2(FEATURE_SLOTS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_NODE,
      S_CMP,
      S_RESULT
   } state_type;

   // Registers
   state_type          state_ff, state_in;
   logic [7:0]         depth_ff, depth_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [31:0]        res_value_ff, res_value_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;
   logic [8:0]         cfg_node_count_ff;
   logic [7:0]         cfg_visit_limit_ff;
   logic [3:0]         cfg_feature_count_ff;

   // Memories
   node_entry_type     node_mem [NODE_ENTRIES];
   node_entry_type     node_q_ff;
   logic [31:0]        feat_mem [FEATURE_SLOTS];
   logic signed [31:0] feat_q_ff;

   req_payload_type    req_pl;
   logic               req_xfer;
   logic               node_we, feat_we;
   logic               node_re, feat_re;
   logic [NODE_AW-1:0] node_raddr;
   logic [FS_AW-1:0]   feat_raddr;
   logic [15:0]        limit;
   logic [15:0]        child;
   logic               feat_below;
   logic               bad_feature;
   logic               child_ok;

   assign req_pl     = req_payload_type'(req_tdata);
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign node_we = req_xfer && (req_tuser == ACT_WRITE_NODE)
                    && (32'(req_pl.node_index) < NODE_ENTRIES);
   assign feat_we = req_xfer && (req_tuser == ACT_WRITE_FEATURE)
                    && (32'(req_pl.feature_slot) < FEATURE_SLOTS);

   // Walk limit: node_count clipped to the table size
   assign limit = (16'(cfg_node_count_ff) > 16'(NODE_ENTRIES)) ?
                  16'(NODE_ENTRIES) : 16'(cfg_node_count_ff);

   assign bad_feature = (16'(node_q_ff.split_feature) >= 16'(cfg_feature_count_ff))
                        || (16'(node_q_ff.split_feature) >= 16'(FEATURE_SLOTS));
   assign feat_below  = feat_q_ff < node_q_ff.split_level;
   assign child       = feat_below ? node_q_ff.left_index : node_q_ff.right_index;
   assign child_ok    = !child[15] && (child < limit) && (depth_ff < cfg_visit_limit_ff);
   assign feat_raddr  = node_q_ff.split_feature[FS_AW-1:0];

   // Writes happen only in idle, so a walk never reads an entry in flight.
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[NODE_AW'(req_pl.node_index)] <= node_entry_type'({
            req_pl.split_feature, req_pl.left_index, req_pl.right_index,
            req_pl.split_level, req_pl.leaf_class});
      end
      if (node_re) begin
         node_q_ff <= node_mem[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem[FS_AW'(req_pl.feature_slot)] <= req_pl.feature_value;
      end
      if (feat_re) begin
         feat_q_ff <= feat_mem[feat_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_node_count_ff    <= '0;
         cfg_visit_limit_ff   <= VISIT_LIMIT_RESET;
         cfg_feature_count_ff <= FEATURE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NODE_COUNT:    cfg_node_count_ff    <= csr_data;
            CSR_VISIT_LIMIT:   cfg_visit_limit_ff   <= csr_data[7:0];
            CSR_FEATURE_COUNT: cfg_feature_count_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      node_re       = 1'b0;
      feat_re       = 1'b0;
      node_raddr    = child[NODE_AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_tuser == ACT_CLASSIFY)) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if ((cfg_visit_limit_ff == 8'd0) || (limit == 16'd0)) begin
               res_status_in = ST_DEPTH;
               res_value_in  = '0;
               state_in      = S_RESULT;
            end else begin
               node_re    = 1'b1;
               node_raddr = '0;
               depth_in   = 8'd1;
               state_in   = S_NODE;
            end
         end
         S_NODE: begin
            if (node_q_ff.split_feature[15]) begin
               res_status_in = ST_OK;
               res_value_in  = node_q_ff.leaf_class;
               state_in      = S_RESULT;
            end else if (bad_feature) begin
               res_status_in = ST_BAD_FEATURE;
               res_value_in  = '0;
               state_in      = S_RESULT;
            end else begin
               feat_re  = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // Issue the next node read straight from the compare
            if (child_ok) begin
               node_re  = 1'b1;
               depth_in = depth_ff + 8'd1;
               state_in = S_NODE;
            end else begin
               res_status_in = ST_DEPTH;
               res_value_in  = '0;
               state_in      = S_RESULT;
            end
         end
         S_RESULT: begin
            // Hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         depth_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   a_fail_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (rsp_status_ff != ST_OK) |-> rsp_value_ff == '0)
      else $error("non-ok result carries a nonzero value");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NODE) |-> (depth_ff != 8'd0) && (depth_ff <= cfg_visit_limit_ff))
      else $error("node visit beyond the visit limit");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT) && rsp_tvalid_ff && !rsp_tready |=>
      (state_ff == S_RESULT) && $stable(rsp_value_ff) && $stable(rsp_status_ff))
      else $error("pending result overwrote an untaken one");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      node_re |-> 16'(node_raddr) < limit)
      else $error("node read beyond node_count");

endmodule

`default_nettype wire
